[hw/rtl/fof_pkg.sv]
package fof_pkg;

  localparam int MAX_PARTICLES_DEF = 512;
  localparam int MAX_HALOS         = 64;
  localparam int HCNT_W            = $clog2(MAX_HALOS + 1);

  localparam int COORD_W = 24;
  localparam int MASS_W  = 24;
  localparam int MSUM_W  = 33;
  localparam int CNT_W   = 10;
  localparam int WSUM_W  = 57;
  localparam int PROD_W  = 49;
  localparam int SQ_W    = 50;
  localparam int LINK_W  = 48;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 120;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_LINK_DIST_SQ = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MEMBERS  = 8'd1;
  localparam logic [CNT_W-1:0]     MIN_MEMBERS_RST  = 10'd8;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_SEED_RD,
    ST_SEED_CHK,
    ST_POP,
    ST_CUR_RD,
    ST_CUR_LAT,
    ST_J_RD,
    ST_J_SQ,
    ST_J_CMP,
    ST_EVAL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PUSH,
    ST_EMIT,
    ST_FINAL
  } fof_state_t;

  typedef struct packed {
    logic       ld_we;
    logic       pos_re;
    logic       lab_re;
    logic       lab_we;
    logic       lab_wd;
    logic       stk_re;
    logic       stk_we;
    logic       acc_clr;
    logic       add;
    logic       sq_en;
    logic       cur_lat;
    logic       div_start;
    logic [1:0] div_k;
    logic       take;
    logic       pend_clr;
  } fof_cmd_t;

  typedef struct packed {
    logic seed_ok;
    logic friend_hit;
    logic qualify;
    logic div_done;
    logic have_pend;
  } fof_sts_t;

endpackage

[hw/rtl/friends_of_friends_halo_finder_unit.sv]
// Sequence: loading stores the particles; after the last particle the grouping
// clears the label of every loaded particle, then for each group member runs a
// three-state distance test against every loaded particle, plus centroid
// division per qualifying halo (57-step divider, three axes).
// Throughput: one run at a time; particles enter at one per cycle while loading.
// Reset: rst is synchronous, clears control state and resets configuration registers.
module friends_of_friends_halo_finder_unit #(
  parameter int MAX_PARTICLES = fof_pkg::MAX_PARTICLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // tdata: pos_x[23:0], pos_y[47:24], pos_z[71:48], particle_mass[95:72]
  input  logic [fof_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: is_active[0]
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tlast,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: centroid_x[23:0], centroid_y[47:24], centroid_z[71:48],
  //        halo_mass[104:72], member_total[114:105], zero fill above
  output logic [fof_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: halo_valid[0]
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fof_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fof_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fof_pkg::*;

  localparam int AW = $clog2(MAX_PARTICLES);

  fof_cmd_t      cmd;
  fof_sts_t      sts;
  logic [AW-1:0] wr_addr, rd_addr, lab_addr, stk_waddr, stk_raddr, stk_wd, stk_q;

  assign cfg_ready = 1'b1;

  fof_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_last(s_axis_tlast), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_last(m_axis_tlast), .out_ready(m_axis_tready),
    .sts, .stk_q, .cmd,
    .wr_addr, .rd_addr, .lab_addr, .stk_waddr, .stk_raddr, .stk_wd
  );

  fof_datapath #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk, .rst, .cmd, .sts,
    .wr_addr, .rd_addr, .lab_addr, .stk_waddr, .stk_raddr, .stk_wd, .stk_q,
    .in_data(s_axis_tdata), .in_active(s_axis_tuser),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_wd(cfg_data),
    .out_data(m_axis_tdata), .out_halo(m_axis_tuser)
  );

  // no particle is taken while a result is offered
  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is offered");

  // an empty result only ever closes a run
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("empty result not marked last");

  // after the closing transaction the block loads again
  a_reload_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not loading after run end");

endmodule

[hw/rtl/fof_ram.sv]
module fof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/fof_div.sv]
module fof_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [fof_pkg::WSUM_W-1:0]   dividend,
  input  logic        [fof_pkg::MSUM_W-1:0]   divisor,
  output logic                                done,
  output logic        [fof_pkg::COORD_W-1:0]  quot
);
  import fof_pkg::*;

  localparam int STEP_W = $clog2(WSUM_W);

  logic [WSUM_W-1:0] mag;
  logic [WSUM_W-1:0] q;
  logic [MSUM_W:0]   rem;
  logic              neg;
  logic              busy;
  logic [STEP_W-1:0] step;
  logic [MSUM_W:0]   rem_sh;
  logic              fits;
  logic [COORD_W-1:0] q_lo;

  assign rem_sh = {rem[MSUM_W-1:0], mag[WSUM_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};
  assign q_lo   = q[COORD_W-1:0];
  // truncate toward zero: divide magnitudes, then restore the sign
  assign quot   = neg ? (~q_lo + 1'b1) : q_lo;

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        neg  <= dividend[WSUM_W-1];
        mag  <= dividend[WSUM_W-1] ? WSUM_W'(-dividend) : WSUM_W'(dividend);
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        rem  <= fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
        q    <= {q[WSUM_W-2:0], fits};
        mag  <= {mag[WSUM_W-2:0], 1'b0};
        step <= step + 1'b1;
        if (step == STEP_W'(WSUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/fof_datapath.sv]
module fof_datapath #(
  parameter int MAX_PARTICLES = fof_pkg::MAX_PARTICLES_DEF,
  localparam int AW = $clog2(MAX_PARTICLES)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fof_pkg::fof_cmd_t                    cmd,
  output fof_pkg::fof_sts_t                    sts,
  input  logic [AW-1:0]                        wr_addr,
  input  logic [AW-1:0]                        rd_addr,
  input  logic [AW-1:0]                        lab_addr,
  input  logic [AW-1:0]                        stk_waddr,
  input  logic [AW-1:0]                        stk_raddr,
  input  logic [AW-1:0]                        stk_wd,
  output logic [AW-1:0]                        stk_q,
  input  logic [fof_pkg::IN_DATA_W-1:0]        in_data,
  input  logic                                 in_active,
  input  logic                                 cfg_we,
  input  logic [fof_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [fof_pkg::CFG_DATA_W-1:0]       cfg_wd,
  output logic [fof_pkg::OUT_DATA_W-1:0]       out_data,
  output logic                                 out_halo
);
  import fof_pkg::*;

  logic [LINK_W-1:0] link_dist_sq;
  logic [CNT_W-1:0]  min_members;

  logic [3*COORD_W-1:0] pos_q;
  logic [MASS_W:0]      ma_q;
  logic                 lab_q;

  logic signed [COORD_W-1:0] px, py, pz, cx, cy, cz;
  logic [MASS_W-1:0]         pm;

  logic [SQ_W-1:0]  sq_x, sq_y, sq_z;
  logic             elig;
  logic [SQ_W+1:0]  dist_sq;

  logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
  logic [MASS_W-1:0]        prod_m;
  logic                     add_pend;

  logic signed [WSUM_W-1:0] wsum_x, wsum_y, wsum_z;
  logic [MSUM_W-1:0]        mass_acc;
  logic [CNT_W-1:0]         cnt_acc;

  logic signed [WSUM_W-1:0] div_num;
  logic                     div_done;
  logic [COORD_W-1:0]       div_q;
  logic [COORD_W-1:0]       new_x, new_y, new_z;

  logic [COORD_W-1:0] pend_x, pend_y, pend_z;
  logic [MSUM_W-1:0]  pend_mass;
  logic [CNT_W-1:0]   pend_cnt;
  logic               have_pend;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      link_dist_sq <= '0;
      min_members  <= MIN_MEMBERS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LINK_DIST_SQ: link_dist_sq <= cfg_wd[LINK_W-1:0];
        CFG_MIN_MEMBERS:  min_members  <= cfg_wd[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // particle stores, label flags and walk stack
  fof_ram #(.WIDTH(3*COORD_W), .DEPTH(MAX_PARTICLES)) u_pos (
    .clk, .we(cmd.ld_we), .waddr(wr_addr), .wdata(in_data[3*COORD_W-1:0]),
    .re(cmd.pos_re), .raddr(rd_addr), .rdata(pos_q)
  );

  fof_ram #(.WIDTH(MASS_W+1), .DEPTH(MAX_PARTICLES)) u_ma (
    .clk, .we(cmd.ld_we), .waddr(wr_addr),
    .wdata({in_active, in_data[IN_DATA_W-1:3*COORD_W]}),
    .re(cmd.pos_re), .raddr(rd_addr), .rdata(ma_q)
  );

  fof_ram #(.WIDTH(1), .DEPTH(MAX_PARTICLES)) u_lab (
    .clk, .we(cmd.lab_we), .waddr(lab_addr), .wdata(cmd.lab_wd),
    .re(cmd.lab_re), .raddr(lab_addr), .rdata(lab_q)
  );

  fof_ram #(.WIDTH(AW), .DEPTH(MAX_PARTICLES)) u_stk (
    .clk, .we(cmd.stk_we), .waddr(stk_waddr), .wdata(stk_wd),
    .re(cmd.stk_re), .raddr(stk_raddr), .rdata(stk_q)
  );

  assign px = pos_q[COORD_W-1:0];
  assign py = pos_q[2*COORD_W-1:COORD_W];
  assign pz = pos_q[3*COORD_W-1:2*COORD_W];
  assign pm = ma_q[MASS_W-1:0];

  function automatic logic [SQ_W-1:0] sq_diff(input logic signed [COORD_W-1:0] a,
                                              input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic        [COORD_W:0] ad;
    d  = (COORD_W+1)'(a) - (COORD_W+1)'(b);
    ad = d[COORD_W] ? (COORD_W+1)'(-d) : d;
    return ad * ad;
  endfunction

  // hold the position of the particle being expanded
  always_ff @(posedge clk) begin
    if (cmd.cur_lat) begin
      cx <= px;
      cy <= py;
      cz <= pz;
    end
  end

  // squared axis distances, registered before the sum
  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      sq_x <= sq_diff(px, cx);
      sq_y <= sq_diff(py, cy);
      sq_z <= sq_diff(pz, cz);
      elig <= ma_q[MASS_W] && !lab_q;
    end
  end

  assign dist_sq = (SQ_W+2)'(sq_x) + (SQ_W+2)'(sq_y) + (SQ_W+2)'(sq_z);

  // weight products, registered before accumulation
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      prod_x <= px * $signed({1'b0, pm});
      prod_y <= py * $signed({1'b0, pm});
      prod_z <= pz * $signed({1'b0, pm});
      prod_m <= pm;
    end
  end

  // group accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      add_pend <= 1'b0;
      wsum_x   <= '0;
      wsum_y   <= '0;
      wsum_z   <= '0;
      mass_acc <= '0;
      cnt_acc  <= '0;
    end else begin
      add_pend <= cmd.add;
      if (cmd.acc_clr) begin
        wsum_x   <= '0;
        wsum_y   <= '0;
        wsum_z   <= '0;
        mass_acc <= '0;
        cnt_acc  <= '0;
      end else if (add_pend) begin
        wsum_x   <= wsum_x + WSUM_W'(prod_x);
        wsum_y   <= wsum_y + WSUM_W'(prod_y);
        wsum_z   <= wsum_z + WSUM_W'(prod_z);
        mass_acc <= mass_acc + MSUM_W'(prod_m);
        cnt_acc  <= cnt_acc + 1'b1;
      end
    end
  end

  // centroid division, one axis at a time
  always_comb begin
    case (cmd.div_k)
      AXIS_X:  div_num = wsum_x;
      AXIS_Y:  div_num = wsum_y;
      default: div_num = wsum_z;
    endcase
  end

  fof_div u_div (
    .clk, .rst, .start(cmd.div_start), .dividend(div_num), .divisor(mass_acc),
    .done(div_done), .quot(div_q)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd.div_k)
        AXIS_X:  new_x <= div_q;
        AXIS_Y:  new_y <= div_q;
        default: new_z <= div_q;
      endcase
    end
  end

  // pending halo, held until the next one shows whether it is the last
  always_ff @(posedge clk) begin
    if (rst) begin
      have_pend <= 1'b0;
    end else if (cmd.pend_clr) begin
      have_pend <= 1'b0;
    end else if (cmd.take) begin
      have_pend <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_x    <= new_x;
      pend_y    <= new_y;
      pend_z    <= new_z;
      pend_mass <= mass_acc;
      pend_cnt  <= cnt_acc;
    end
  end

  assign out_halo = have_pend;
  assign out_data = have_pend
                  ? {5'b0, pend_cnt, pend_mass, pend_z, pend_y, pend_x}
                  : '0;

  assign sts.seed_ok    = ma_q[MASS_W] && !lab_q;
  assign sts.friend_hit = elig && (dist_sq < (SQ_W+2)'(link_dist_sq));
  assign sts.qualify    = (mass_acc != '0) && (cnt_acc >= min_members);
  assign sts.div_done   = div_done;
  assign sts.have_pend  = have_pend;

endmodule

[hw/rtl/fof_ctrl.sv]
module fof_ctrl #(
  parameter int MAX_PARTICLES = fof_pkg::MAX_PARTICLES_DEF,
  localparam int AW = $clog2(MAX_PARTICLES),
  localparam int CW = $clog2(MAX_PARTICLES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  output logic              out_last,
  input  logic              out_ready,
  input  fof_pkg::fof_sts_t sts,
  input  logic [AW-1:0]     stk_q,
  output fof_pkg::fof_cmd_t cmd,
  output logic [AW-1:0]     wr_addr,
  output logic [AW-1:0]     rd_addr,
  output logic [AW-1:0]     lab_addr,
  output logic [AW-1:0]     stk_waddr,
  output logic [AW-1:0]     stk_raddr,
  output logic [AW-1:0]     stk_wd
);
  import fof_pkg::*;

  fof_state_t state, state_next;
  logic [CW-1:0]     ld_cnt, ld_cnt_next;
  logic [CW-1:0]     n, n_next;
  logic [CW-1:0]     i, i_next;
  logic [CW-1:0]     j, j_next;
  logic [CW-1:0]     sp, sp_next;
  logic [CW-1:0]     clr, clr_next;
  logic [HCNT_W-1:0] hcnt, hcnt_next;
  logic [1:0]        k, k_next;
  logic              room;

  assign room      = ld_cnt < CW'(MAX_PARTICLES);
  assign wr_addr   = ld_cnt[AW-1:0];
  assign stk_waddr = sp[AW-1:0];
  assign stk_raddr = AW'(sp - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      ld_cnt <= '0;
      n      <= '0;
      i      <= '0;
      j      <= '0;
      sp     <= '0;
      clr    <= '0;
      hcnt   <= '0;
      k      <= '0;
    end else begin
      state  <= state_next;
      ld_cnt <= ld_cnt_next;
      n      <= n_next;
      i      <= i_next;
      j      <= j_next;
      sp     <= sp_next;
      clr    <= clr_next;
      hcnt   <= hcnt_next;
      k      <= k_next;
    end
  end

  always_comb begin
    state_next  = state;
    ld_cnt_next = ld_cnt;
    n_next      = n;
    i_next      = i;
    j_next      = j;
    sp_next     = sp;
    clr_next    = clr;
    hcnt_next   = hcnt;
    k_next      = k;
    cmd         = '0;
    cmd.div_k   = k;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    out_last    = 1'b0;
    rd_addr     = j[AW-1:0];
    lab_addr    = j[AW-1:0];
    stk_wd      = j[AW-1:0];

    case (state)
      // store particles until the last one
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_we = room;
          if (room) begin
            ld_cnt_next = ld_cnt + 1'b1;
          end
          if (in_last) begin
            n_next     = room ? CW'(ld_cnt + 1'b1) : ld_cnt;
            clr_next   = '0;
            state_next = ST_CLEAR;
          end
        end
      end
      // mark every loaded particle unassigned
      ST_CLEAR: begin
        cmd.lab_we = 1'b1;
        cmd.lab_wd = 1'b0;
        lab_addr   = clr[AW-1:0];
        clr_next   = clr + 1'b1;
        if (CW'(clr + 1'b1) == n) begin
          i_next       = '0;
          sp_next      = '0;
          hcnt_next    = '0;
          cmd.pend_clr = 1'b1;
          state_next   = ST_SEED_RD;
        end
      end
      ST_SEED_RD: begin
        rd_addr  = i[AW-1:0];
        lab_addr = i[AW-1:0];
        if (i == n) begin
          state_next = ST_FINAL;
        end else begin
          cmd.pos_re = 1'b1;
          cmd.lab_re = 1'b1;
          state_next = ST_SEED_CHK;
        end
      end
      // open a new group at an unassigned active particle
      ST_SEED_CHK: begin
        rd_addr  = i[AW-1:0];
        lab_addr = i[AW-1:0];
        stk_wd   = i[AW-1:0];
        if (sts.seed_ok) begin
          cmd.acc_clr = 1'b1;
          cmd.add     = 1'b1;
          cmd.lab_we  = 1'b1;
          cmd.lab_wd  = 1'b1;
          cmd.stk_we  = 1'b1;
          sp_next     = sp + 1'b1;
          state_next  = ST_POP;
        end else begin
          i_next     = i + 1'b1;
          state_next = ST_SEED_RD;
        end
      end
      ST_POP: begin
        if (sp == '0) begin
          state_next = ST_EVAL;
        end else begin
          cmd.stk_re = 1'b1;
          sp_next    = sp - 1'b1;
          state_next = ST_CUR_RD;
        end
      end
      ST_CUR_RD: begin
        rd_addr    = stk_q;
        cmd.pos_re = 1'b1;
        state_next = ST_CUR_LAT;
      end
      ST_CUR_LAT: begin
        cmd.cur_lat = 1'b1;
        j_next      = '0;
        state_next  = ST_J_RD;
      end
      // scan all particles against the current one
      ST_J_RD: begin
        cmd.pos_re = 1'b1;
        cmd.lab_re = 1'b1;
        state_next = ST_J_SQ;
      end
      ST_J_SQ: begin
        cmd.sq_en  = 1'b1;
        state_next = ST_J_CMP;
      end
      ST_J_CMP: begin
        if (sts.friend_hit) begin
          cmd.add    = 1'b1;
          cmd.lab_we = 1'b1;
          cmd.lab_wd = 1'b1;
          cmd.stk_we = sp < CW'(MAX_PARTICLES);
          if (sp < CW'(MAX_PARTICLES)) begin
            sp_next = sp + 1'b1;
          end
        end
        j_next = j + 1'b1;
        if (CW'(j + 1'b1) == n) begin
          state_next = ST_POP;
        end else begin
          state_next = ST_J_RD;
        end
      end
      ST_EVAL: begin
        if (sts.qualify) begin
          k_next     = AXIS_X;
          state_next = ST_DIV_GO;
        end else begin
          i_next     = i + 1'b1;
          state_next = ST_SEED_RD;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          k_next = k + 1'b1;
          if (k == AXIS_Z) begin
            state_next = ST_PUSH;
          end else begin
            state_next = ST_DIV_GO;
          end
        end
      end
      // release the held halo, then hold the new one
      ST_PUSH: begin
        if (sts.have_pend) begin
          state_next = ST_EMIT;
        end else begin
          cmd.take  = 1'b1;
          hcnt_next = hcnt + 1'b1;
          i_next    = i + 1'b1;
          if (HCNT_W'(hcnt + 1'b1) == HCNT_W'(MAX_HALOS)) begin
            state_next = ST_FINAL;
          end else begin
            state_next = ST_SEED_RD;
          end
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.take  = 1'b1;
          hcnt_next = hcnt + 1'b1;
          i_next    = i + 1'b1;
          if (HCNT_W'(hcnt + 1'b1) == HCNT_W'(MAX_HALOS)) begin
            state_next = ST_FINAL;
          end else begin
            state_next = ST_SEED_RD;
          end
        end
      end
      ST_FINAL: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
        if (out_ready) begin
          ld_cnt_next = '0;
          state_next  = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

[bench/friends_of_friends_halo_finder_unit_test.sv]
module friends_of_friends_halo_finder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fof_pkg::*;

  localparam int NMAX = MAX_PARTICLES_DEF;
  localparam int IDLE_LIMIT = 2000000;

  typedef struct packed {
    logic              valid;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
    logic [MSUM_W-1:0] msum;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } halo_t;

  // Grouping predictor and queue of expected halos
  class halo_scoreboard;
    logic signed [COORD_W-1:0] px[NMAX], py[NMAX], pz[NMAX];
    logic [MASS_W-1:0] pm[NMAX];
    bit act[NMAX];
    int loaded;
    logic [LINK_W-1:0] link_sq;
    logic [CNT_W-1:0] min_cnt;
    halo_t pending[$];
    int errors;

    function new();
      loaded = 0;
      link_sq = '0;
      min_cnt = MIN_MEMBERS_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == CFG_LINK_DIST_SQ) link_sq = d[LINK_W-1:0];
      else if (idx == CFG_MIN_MEMBERS) min_cnt = d[CNT_W-1:0];
    endfunction

    function bit linked(int a, int b);
      longint da, db, dc;
      logic [63:0] s;
      da = longint'(px[a]) - longint'(px[b]);
      db = longint'(py[a]) - longint'(py[b]);
      dc = longint'(pz[a]) - longint'(pz[b]);
      s = da * da + db * db + dc * dc;
      return s < {16'd0, link_sq};
    endfunction

    function void note_particle(logic [IN_DATA_W-1:0] d, bit a, bit l);
      bit lab[NMAX];
      int stk[NMAX];
      int sp;
      longint wx, wy, wz;
      longint unsigned ms;
      int cnt, cur, nout;
      halo_t h;
      if (loaded < NMAX) begin
        px[loaded] = d[23:0];
        py[loaded] = d[47:24];
        pz[loaded] = d[71:48];
        pm[loaded] = d[95:72];
        act[loaded] = a;
        loaded++;
      end
      if (!l) return;
      nout = 0;
      for (int i = 0; i < loaded; i++) lab[i] = 0;
      for (int i = 0; i < loaded; i++) begin
        if (!act[i] || lab[i]) continue;
        lab[i] = 1;
        wx = longint'(px[i]) * longint'(pm[i]);
        wy = longint'(py[i]) * longint'(pm[i]);
        wz = longint'(pz[i]) * longint'(pm[i]);
        ms = pm[i];
        cnt = 1;
        sp = 0;
        stk[sp] = i;
        sp++;
        while (sp > 0) begin
          sp--;
          cur = stk[sp];
          for (int j = 0; j < loaded; j++) begin
            if (lab[j] || !act[j]) continue;
            if (linked(j, cur)) begin
              lab[j] = 1;
              wx += longint'(px[j]) * longint'(pm[j]);
              wy += longint'(py[j]) * longint'(pm[j]);
              wz += longint'(pz[j]) * longint'(pm[j]);
              ms += pm[j];
              cnt++;
              stk[sp] = j;
              sp++;
            end
          end
        end
        if (ms > 0 && cnt >= min_cnt && nout < MAX_HALOS) begin
          h.valid = 1;
          h.cx = COORD_W'(wx / longint'(ms));
          h.cy = COORD_W'(wy / longint'(ms));
          h.cz = COORD_W'(wz / longint'(ms));
          h.msum = MSUM_W'(ms);
          h.cnt = CNT_W'(cnt);
          h.last = 0;
          pending.insert(pending.size(), h);
          nout++;
        end
      end
      if (nout == 0) begin
        h = '0;
        h.last = 1;
        pending.insert(pending.size(), h);
      end else begin
        pending[pending.size()-1].last = 1;
      end
      loaded = 0;
    endfunction

    function void check_halo(halo_t got);
      halo_t w;
      if (pending.size() == 0) begin
        $display("%0t unexpected halo result %p", $time, got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.valid !== w.valid) begin
        $display("%0t halo_valid exp %0d got %0d", $time, w.valid, got.valid); errors++;
      end
      if (got.cx !== w.cx) begin
        $display("%0t centroid_x exp %h got %h", $time, w.cx, got.cx); errors++;
      end
      if (got.cy !== w.cy) begin
        $display("%0t centroid_y exp %h got %h", $time, w.cy, got.cy); errors++;
      end
      if (got.cz !== w.cz) begin
        $display("%0t centroid_z exp %h got %h", $time, w.cz, got.cz); errors++;
      end
      if (got.msum !== w.msum) begin
        $display("%0t halo_mass exp %h got %h", $time, w.msum, got.msum); errors++;
      end
      if (got.cnt !== w.cnt) begin
        $display("%0t member_total exp %0d got %0d", $time, w.cnt, got.cnt); errors++;
      end
      if (got.last !== w.last) begin
        $display("%0t last_halo exp %0d got %0d", $time, w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0, s_axis_tlast = 0, s_axis_tvalid = 0, s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser, m_axis_tlast, m_axis_tvalid, m_axis_tready = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  halo_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_off = 0;
  bit pattern_on = 1;

  friends_of_friends_halo_finder_unit dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Score accepted transactions at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_particle(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_halo({m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[47:24],
                       m_axis_tdata[71:48], m_axis_tdata[104:72],
                       m_axis_tdata[114:105], m_axis_tlast});
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver stall pattern, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_off) m_axis_tready <= 0;
    else if (!pattern_on) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_particle(logic [23:0] x, y, z, m, bit a, bit l);
    s_axis_tdata <= {m, z, y, x};
    s_axis_tuser <= a;
    s_axis_tlast <= l;
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int g;
    s_axis_tvalid <= 0;
    g = $urandom_range(1, 6);
    repeat (g) @(negedge clk);
  endtask

  // Wait for every halo, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // Cluster of k particles near a random center, in bursts
  task automatic send_cluster_set(int groups, int k, int spread, bit lastset);
    logic signed [23:0] cx, cy, cz;
    int burst;
    burst = $urandom_range(1, 8);
    for (int g = 0; g < groups; g++) begin
      cx = 24'($urandom); cy = 24'($urandom); cz = 24'($urandom);
      for (int i = 0; i < k; i++) begin
        send_particle(24'(cx + $signed($urandom_range(0, 2*spread)) - spread),
                      24'(cy + $signed($urandom_range(0, 2*spread)) - spread),
                      24'(cz + $signed($urandom_range(0, 2*spread)) - spread),
                      ($urandom_range(0, 9) == 0) ? 24'd0 : 24'($urandom),
                      $urandom_range(0, 7) != 0,
                      lastset && g == groups-1 && i == k-1);
        if (--burst == 0) begin
          sender_gap();
          burst = $urandom_range(1, 8);
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: reset config, link 0 means no friends, single group of one
    send_particle(24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 1, 1);
    drain();
    write_reg(CFG_MIN_MEMBERS, 48'd1);
    write_reg(CFG_LINK_DIST_SQ, 48'hFFFF_FFFF_FFFF);
    // Extremes of position and mass, inactive and zero-mass particles
    send_particle(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 1, 0);
    send_particle(24'h800000, 24'h800000, 24'h800000, 24'hFFFFFF, 1, 0);
    send_particle(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1, 0);
    send_particle(24'h123456, 24'hABCDEF, 24'h000001, 24'h000001, 0, 1);
    drain();
    // Zero min_members, zero-mass only group gives no halo
    write_reg(CFG_MIN_MEMBERS, 48'd0);
    write_reg(CFG_LINK_DIST_SQ, 48'd0);
    send_particle(24'h000010, 24'h000020, 24'h000030, 24'h000000, 1, 1);
    drain();
    // Unknown index and wide data
    write_reg(8'hFF, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_MIN_MEMBERS, 48'hFFFF_FFFF_F801);
    write_reg(CFG_LINK_DIST_SQ, 48'd1);
    // Nonexistent big group then min 512 so nothing qualifies
    send_cluster_set(2, 3, 0, 1);
    drain();
    write_reg(CFG_MIN_MEMBERS, 48'd512);
    send_cluster_set(1, 4, 2, 1);
    drain();
    // More than 64 halos: 70 isolated particles
    write_reg(CFG_MIN_MEMBERS, 48'd1);
    write_reg(CFG_LINK_DIST_SQ, 48'd0);
    for (int i = 0; i < 70; i++)
      send_particle(24'($urandom), 24'($urandom), 24'($urandom),
                    24'($urandom_range(1, 100)), 1, i == 69);
    drain();

    // Random sets of clusters
    for (int r = 0; r < 5; r++) begin
      write_reg(CFG_LINK_DIST_SQ, {16'd0, 32'd1} << $urandom_range(8, 34));
      write_reg(CFG_MIN_MEMBERS, 48'($urandom_range(1, 4)));
      if (r == 3) fork
        begin
          hold_off = 1;
          repeat (400) @(negedge clk);
          hold_off = 0;
        end
      join_none
      pattern_on = (r % 3 != 0);
      send_cluster_set($urandom_range(1, 4), $urandom_range(1, 5), 1 << $urandom_range(0, 9),
                       0);
      // noise particles
      repeat ($urandom_range(0, 3))
        send_particle(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                      1'($urandom), 0);
      send_particle(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                    1'($urandom), 1);
      drain();
    end

    // Hold the receiver off while the next set keeps waiting at the input
    pattern_on = 1;
    fork
      begin
        hold_off = 1;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
    join_none
    send_cluster_set(2, 4, 4, 1);
    send_cluster_set(2, 4, 4, 1);
    drain();

    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
